[hw/rtl/tppq_pkg.sv]
// Shared types and constants of the two-priority pushout queue.
// No dependencies; imported by every other file of the block except tppq_ram.
package tppq_pkg;

    localparam int TAG_W   = 16;
    localparam int BYTES_W = 14;
    localparam int OCC_W   = 24;
    localparam int ENTRY_W = TAG_W + BYTES_W;

    localparam logic [1:0] OP_ARRIVAL  = 2'd0;
    localparam logic [1:0] OP_PAUSE    = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    localparam logic [1:0] EV_ENQ    = 2'd0;
    localparam logic [1:0] EV_DROP   = 2'd1;
    localparam logic [1:0] EV_START  = 2'd2;
    localparam logic [1:0] EV_DEPART = 2'd3;

    localparam logic [1:0] SEND_READY          = 2'd0;
    localparam logic [1:0] SEND_PAUSE_RECEIVED = 2'd1;
    localparam logic [1:0] SEND_PAUSED         = 2'd2;

    localparam logic [1:0] SERVE_NONE = 2'd0;
    localparam logic [1:0] SERVE_HIGH = 2'd1;
    localparam logic [1:0] SERVE_LOW  = 2'd2;

    localparam logic ECN_CE = 1'b1;

    localparam logic CFG_MAX_BYTES     = 1'b0;
    localparam logic CFG_ECN_THRESHOLD = 1'b1;

    localparam logic [OCC_W-1:0] MAX_BYTES_RESET = 24'd65536;
    localparam logic [OCC_W-1:0] ECN_THR_RESET   = 24'd32768;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic               is_high;
        logic               pause_on;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TAG_W-1:0]   tag;
        logic [BYTES_W-1:0] bytes;
        logic               from_high;
        logic               ecn;
        logic [OCC_W-1:0]   occ;
        logic               last;
    } res_t;

endpackage

[hw/rtl/tppq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tppq_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hw/rtl/tppq_front.sv]
// Front end: accepts command items and holds them in a two-entry queue.
// Depends on tppq_pkg.
module tppq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  tppq_pkg::cmd_t in_cmd,
    output logic          busy,
    output logic          cmd_valid,
    output tppq_pkg::cmd_t cmd,
    input  logic          cmd_ready
);
    import tppq_pkg::*;

    cmd_t       slot_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    assign busy      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = start && !busy;
    assign pop       = cmd_valid && cmd_ready;

    // advance pointers and fill level
    always_comb
    begin
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // hold the item in its slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

[hw/rtl/tppq_back.sv]
// Back end: queue state, pushout, service and departure sequencer.
// Depends on tppq_pkg and tppq_ram.
module tppq_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  tppq_pkg::cmd_t            cmd,
    output logic                      cmd_ready,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [tppq_pkg::OCC_W-1:0] cfg_data,
    output logic                      res_strobe,
    output tppq_pkg::res_t            res
);
    import tppq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   DEPTH_W = (CW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_EXEC       = 3'd1;
    localparam logic [2:0] S_PUSH_RD    = 3'd2;
    localparam logic [2:0] S_PUSH_EMIT  = 3'd3;
    localparam logic [2:0] S_START_RD   = 3'd4;
    localparam logic [2:0] S_START_EMIT = 3'd5;
    localparam logic [2:0] S_DEP_RD     = 3'd6;
    localparam logic [2:0] S_DEP_EMIT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    cmd_t              cmd_reg;
    logic [PW-1:0]     hi_head_reg, hi_head_next, lo_head_reg, lo_head_next;
    logic [CW-1:0]     hi_cnt_reg, hi_cnt_next, lo_cnt_reg, lo_cnt_next;
    logic [OCC_W-1:0]  qb_reg, qb_next;
    logic [1:0]        send_reg, send_next, serve_reg, serve_next;
    logic [OCC_W-1:0]  max_reg, thr_reg;
    logic              strobe_reg, strobe_next;
    res_t              res_reg, res_next;

    logic [CW:0]       wr_sum, tail_sum;
    logic [PW-1:0]     wr_idx, tail_idx, rd_addr;
    logic [CW-1:0]     cls_cnt, guard;
    logic [OCC_W:0]    need;
    logic              hi_we, lo_we;
    logic [ENTRY_W-1:0] hi_rdata, lo_rdata, sel_data;
    logic [BYTES_W-1:0] sel_bytes;
    logic [OCC_W-1:0]  ext_bytes;
    logic [1:0]        send_after;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign res_strobe = strobe_reg;
    assign res        = res_reg;

    // ring index arithmetic
    always_comb
    begin
        cls_cnt  = cmd_reg.is_high ? hi_cnt_reg : lo_cnt_reg;
        wr_sum   = (CW+1)'(cmd_reg.is_high ? hi_head_reg : lo_head_reg) + (CW+1)'(cls_cnt);
        wr_idx   = PW'((wr_sum >= DEPTH_W) ? wr_sum - DEPTH_W : wr_sum);
        tail_sum = (CW+1)'(lo_head_reg) + (CW+1)'(lo_cnt_reg) - (CW+1)'(1);
        tail_idx = PW'((tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum);
        guard    = (serve_reg == SERVE_LOW) ? CW'(1) : CW'(0);
        need     = (OCC_W+1)'(qb_reg) + (OCC_W+1)'(cmd_reg.bytes);
    end

    // choose read address by sequencer step
    always_comb
    begin
        unique case (state_reg)
            S_PUSH_RD:  rd_addr = tail_idx;
            S_START_RD: rd_addr = (hi_cnt_reg != '0) ? hi_head_reg : lo_head_reg;
            S_DEP_RD:   rd_addr = (serve_reg == SERVE_HIGH) ? hi_head_reg : lo_head_reg;
            default:    rd_addr = hi_head_reg;
        endcase
    end

    assign hi_we = (state_reg == S_EXEC) && (cmd_reg.opcode == OP_ARRIVAL) && cmd_reg.is_high
                   && (cls_cnt < DEPTH_C) && !(need > (OCC_W+1)'(max_reg));
    assign lo_we = (state_reg == S_EXEC) && (cmd_reg.opcode == OP_ARRIVAL) && !cmd_reg.is_high
                   && (cls_cnt < DEPTH_C) && !(need > (OCC_W+1)'(max_reg));

    tppq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_high_ram (
        .clk   (clk),
        .we    (hi_we),
        .waddr (wr_idx),
        .wdata ({cmd_reg.bytes, cmd_reg.tag}),
        .raddr (rd_addr),
        .rdata (hi_rdata)
    );

    tppq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_low_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (wr_idx),
        .wdata ({cmd_reg.bytes, cmd_reg.tag}),
        .raddr (rd_addr),
        .rdata (lo_rdata)
    );

    always_comb
    begin
        sel_data  = (state_reg == S_PUSH_EMIT || serve_reg == SERVE_LOW) ? lo_rdata : hi_rdata;
        sel_bytes = sel_data[ENTRY_W-1:TAG_W];
        ext_bytes = OCC_W'(sel_bytes);
    end

    // sequence one item
    always_comb
    begin
        state_next   = state_reg;
        hi_head_next = hi_head_reg;
        lo_head_next = lo_head_reg;
        hi_cnt_next  = hi_cnt_reg;
        lo_cnt_next  = lo_cnt_reg;
        qb_next      = qb_reg;
        send_next    = send_reg;
        serve_next   = serve_reg;
        strobe_next  = 1'b0;
        send_after   = (send_reg == SEND_PAUSE_RECEIVED) ? SEND_PAUSED : send_reg;
        res_next     = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                priority case (cmd_reg.opcode)
                    OP_ARRIVAL:
                    begin
                        res_next.tag       = cmd_reg.tag;
                        res_next.bytes     = cmd_reg.bytes;
                        res_next.from_high = cmd_reg.is_high;
                        res_next.ecn       = 1'b0;
                        res_next.occ       = qb_reg;
                        if (cls_cnt >= DEPTH_C)
                        begin
                            strobe_next   = 1'b1;
                            res_next.kind = EV_DROP;
                            res_next.last = 1'b1;
                        end
                        else if (need > (OCC_W+1)'(max_reg))
                        begin
                            if (cmd_reg.is_high && lo_cnt_reg > guard)
                            begin
                                state_next = S_PUSH_RD;
                            end
                            else
                            begin
                                strobe_next   = 1'b1;
                                res_next.kind = EV_DROP;
                                res_next.last = 1'b1;
                            end
                        end
                        else
                        begin
                            // store the arrival and maybe start service
                            if (cmd_reg.is_high)
                            begin
                                hi_cnt_next = hi_cnt_reg + CW'(1);
                            end
                            else
                            begin
                                lo_cnt_next = lo_cnt_reg + CW'(1);
                            end
                            qb_next       = OCC_W'(need);
                            strobe_next   = 1'b1;
                            res_next.kind = EV_ENQ;
                            res_next.occ  = OCC_W'(need);
                            res_next.last = !(serve_reg == SERVE_NONE && send_reg == SEND_READY);
                            if (serve_reg == SERVE_NONE && send_reg == SEND_READY)
                            begin
                                state_next = S_START_RD;
                            end
                        end
                    end
                    OP_PAUSE:
                    begin
                        if (cmd_reg.pause_on)
                        begin
                            send_next = (serve_reg != SERVE_NONE) ? SEND_PAUSE_RECEIVED
                                                                  : SEND_PAUSED;
                        end
                        else
                        begin
                            send_next = SEND_READY;
                            if (serve_reg == SERVE_NONE
                                && (hi_cnt_reg != '0 || lo_cnt_reg != '0))
                            begin
                                state_next = S_START_RD;
                            end
                        end
                    end
                    OP_COMPLETE:
                    begin
                        if (serve_reg == SERVE_HIGH || serve_reg == SERVE_LOW)
                        begin
                            if ((serve_reg == SERVE_HIGH ? hi_cnt_reg : lo_cnt_reg) == '0)
                            begin
                                serve_next = SERVE_NONE;
                            end
                            else
                            begin
                                state_next = S_DEP_RD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_PUSH_RD:
            begin
                state_next = S_PUSH_EMIT;
            end
            S_PUSH_EMIT:
            begin
                // drop the newest low packet, then test the limit again
                lo_cnt_next        = lo_cnt_reg - CW'(1);
                qb_next            = qb_reg - ext_bytes;
                strobe_next        = 1'b1;
                res_next.kind      = EV_DROP;
                res_next.tag       = sel_data[TAG_W-1:0];
                res_next.bytes     = sel_bytes;
                res_next.from_high = 1'b0;
                res_next.ecn       = 1'b0;
                res_next.occ       = qb_reg - ext_bytes;
                res_next.last      = 1'b0;
                state_next         = S_EXEC;
            end
            S_START_RD:
            begin
                serve_next = (hi_cnt_reg != '0) ? SERVE_HIGH : SERVE_LOW;
                state_next = S_START_EMIT;
            end
            S_START_EMIT:
            begin
                strobe_next        = 1'b1;
                res_next.kind      = EV_START;
                res_next.tag       = sel_data[TAG_W-1:0];
                res_next.bytes     = sel_bytes;
                res_next.from_high = (serve_reg == SERVE_HIGH);
                res_next.ecn       = 1'b0;
                res_next.occ       = qb_reg;
                res_next.last      = 1'b1;
                state_next         = S_IDLE;
            end
            S_DEP_RD:
            begin
                state_next = S_DEP_EMIT;
            end
            S_DEP_EMIT:
            begin
                // retire the head packet of the serving class
                if (serve_reg == SERVE_HIGH)
                begin
                    hi_head_next = (hi_head_reg == LAST_P) ? '0 : hi_head_reg + PW'(1);
                    hi_cnt_next  = hi_cnt_reg - CW'(1);
                end
                else
                begin
                    lo_head_next = (lo_head_reg == LAST_P) ? '0 : lo_head_reg + PW'(1);
                    lo_cnt_next  = lo_cnt_reg - CW'(1);
                end
                send_next          = send_after;
                qb_next            = (ext_bytes <= qb_reg) ? qb_reg - ext_bytes : '0;
                serve_next         = SERVE_NONE;
                strobe_next        = 1'b1;
                res_next.kind      = EV_DEPART;
                res_next.tag       = sel_data[TAG_W-1:0];
                res_next.bytes     = sel_bytes;
                res_next.from_high = (serve_reg == SERVE_HIGH);
                res_next.ecn       = (qb_reg > thr_reg) ? ECN_CE : 1'b0;
                res_next.occ       = (ext_bytes <= qb_reg) ? qb_reg - ext_bytes : '0;
                if (send_after == SEND_READY && (hi_cnt_next != '0 || lo_cnt_next != '0))
                begin
                    res_next.last = 1'b0;
                    state_next    = S_START_RD;
                end
                else
                begin
                    res_next.last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hi_head_reg <= '0;
            lo_head_reg <= '0;
            hi_cnt_reg  <= '0;
            lo_cnt_reg  <= '0;
            qb_reg      <= '0;
            send_reg    <= SEND_READY;
            serve_reg   <= SERVE_NONE;
            strobe_reg  <= 1'b0;
            max_reg     <= MAX_BYTES_RESET;
            thr_reg     <= ECN_THR_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            hi_head_reg <= hi_head_next;
            lo_head_reg <= lo_head_next;
            hi_cnt_reg  <= hi_cnt_next;
            lo_cnt_reg  <= lo_cnt_next;
            qb_reg      <= qb_next;
            send_reg    <= send_next;
            serve_reg   <= serve_next;
            strobe_reg  <= strobe_next;
            if (cfg_we && cfg_index == CFG_MAX_BYTES)
            begin
                max_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_ECN_THRESHOLD)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // hold the command and the result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        res_reg <= res_next;
    end

    a_high_serving_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        serve_reg == SERVE_HIGH |-> hi_cnt_reg != '0)
        else $error("serving high class with empty high queue");

    a_low_serving_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        serve_reg == SERVE_LOW |-> lo_cnt_reg != '0)
        else $error("serving low class with empty low queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hi_cnt_reg <= DEPTH_C && lo_cnt_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    a_pushout_keeps_served: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PUSH_RD |-> lo_cnt_reg > guard)
        else $error("pushout would remove the packet in service");
endmodule

[hw/rtl/two_priority_pushout_queue_ecn.sv]
// Top level of the two-priority pushout queue with ECN marking.
// Depends on tppq_pkg, tppq_front, tppq_back (which uses tppq_ram).
//
// Usage: drive opcode and packet fields with start; an item is taken at an
// edge where start is high and busy is low. Opcode 0 is an arrival, 1 a
// pause frame (pause_on selects pause or resume), 2 service complete.
// Results come out on the result ports, each one marked by strobe;
// last flags the final result of an item. The receiver cannot stall, so
// every strobe cycle is a delivered result.
// Sequencing: the front holds up to two items; the back sequencer takes
// an item while idle and then executes it, plus a read, a drop and a new
// test of the limit per pushed-out packet, and a read and an emit per
// service start or departure, since each of those reads a queue RAM with a
// registered read port. The back takes no new item until it is idle again.
// Configuration: cfg_we with cfg_index 0 writes max_bytes, 1 writes
// ecn_threshold; write only while the block is idle.
// Reset: queues empty, occupancy zero, sending ready, nothing in service,
// max_bytes 65536, ecn_threshold 32768.
module two_priority_pushout_queue_ecn #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] packet_tag,
    input  logic [13:0] packet_bytes,
    input  logic        is_high,
    input  logic        pause_on,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    output logic        strobe,
    output logic [1:0]  event_kind,
    output logic [15:0] out_tag,
    output logic [13:0] out_bytes,
    output logic        from_high,
    output logic        ecn_marked,
    output logic [23:0] occupancy,
    output logic        last
);
    import tppq_pkg::*;

    cmd_t in_cmd, cmd;
    logic cmd_valid, cmd_ready;
    res_t res;

    assign in_cmd = '{opcode: opcode, tag: packet_tag, bytes: packet_bytes,
                      is_high: is_high, pause_on: pause_on};

    tppq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_cmd    (in_cmd),
        .busy      (busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    tppq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .res_strobe (strobe),
        .res        (res)
    );

    // unpack the result item
    assign event_kind = res.kind;
    assign out_tag    = res.tag;
    assign out_bytes  = res.bytes;
    assign from_high  = res.from_high;
    assign ecn_marked = res.ecn;
    assign occupancy  = res.occ;
    assign last       = res.last;
endmodule

[tb/two_priority_pushout_queue_ecn_tb.sv]
// Self-checking testbench for the two-priority pushout queue with ECN marking.
// Depends on tppq_pkg and two_priority_pushout_queue_ecn; holds its own queue model.
module two_priority_pushout_queue_ecn_tb;
    import tppq_pkg::*;

    localparam int DEPTH     = 32;
    localparam int LIMIT     = 600000;
    localparam int SETTLE    = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [15:0] packet_tag;
    logic [13:0] packet_bytes;
    logic        is_high;
    logic        pause_on;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        strobe;
    logic [1:0]  event_kind;
    logic [15:0] out_tag;
    logic [13:0] out_bytes;
    logic        from_high;
    logic        ecn_marked;
    logic [23:0] occupancy;
    logic        last;

    two_priority_pushout_queue_ecn #(.QUEUE_DEPTH(DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .packet_tag(packet_tag), .packet_bytes(packet_bytes),
        .is_high(is_high), .pause_on(pause_on),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .strobe(strobe), .event_kind(event_kind), .out_tag(out_tag),
        .out_bytes(out_bytes), .from_high(from_high), .ecn_marked(ecn_marked),
        .occupancy(occupancy), .last(last)
    );

    always #6 clk = ~clk;

    // Queue model state
    logic [ENTRY_W-1:0] hi_ring [DEPTH];
    logic [ENTRY_W-1:0] lo_ring [DEPTH];
    int unsigned hi_head, hi_cnt, lo_head, lo_cnt;
    int unsigned queued, cap_bytes, mark_thr;
    logic [1:0]  send_st, serving;

    res_t pending_events [$];
    int   fail_cnt;
    int   cycle_cnt;
    bit   no_idle;

    // Append one predicted result at the current occupancy
    function automatic void note_event(input logic [1:0] kind, input logic [ENTRY_W-1:0] e,
                                       input logic hi, input logic ecn);
        res_t r;
        r.kind      = kind;
        r.tag       = e[TAG_W-1:0];
        r.bytes     = e[ENTRY_W-1:TAG_W];
        r.from_high = hi;
        r.ecn       = ecn;
        r.occ       = queued[OCC_W-1:0];
        r.last      = 1'b0;
        pending_events.push_back(r);
    endfunction

    function automatic void begin_service();
        if (hi_cnt > 0) begin
            serving = SERVE_HIGH;
            note_event(EV_START, hi_ring[hi_head % DEPTH], 1'b1, 1'b0);
        end else if (lo_cnt > 0) begin
            serving = SERVE_LOW;
            note_event(EV_START, lo_ring[lo_head % DEPTH], 1'b0, 1'b0);
        end else begin
            serving = SERVE_NONE;
        end
    endfunction

    function automatic void model_arrival(input logic [15:0] tag, input logic [13:0] nb,
                                          input logic hi);
        logic [ENTRY_W-1:0] e;
        logic [ENTRY_W-1:0] v;
        int unsigned guard, idx;
        e = {nb, tag};
        if ((hi ? hi_cnt : lo_cnt) >= DEPTH) begin
            note_event(EV_DROP, e, hi, 1'b0);
            return;
        end
        // Push out newest low packets, never the one in service
        while (queued + nb > cap_bytes) begin
            guard = (serving == SERVE_LOW) ? 1 : 0;
            if (hi && lo_cnt > guard) begin
                idx = (lo_head + lo_cnt - 1) % DEPTH;
                v = lo_ring[idx];
                lo_cnt--;
                queued -= v[ENTRY_W-1:TAG_W];
                note_event(EV_DROP, v, 1'b0, 1'b0);
            end else begin
                note_event(EV_DROP, e, hi, 1'b0);
                return;
            end
        end
        if (hi) begin
            hi_ring[(hi_head + hi_cnt) % DEPTH] = e;
            hi_cnt++;
        end else begin
            lo_ring[(lo_head + lo_cnt) % DEPTH] = e;
            lo_cnt++;
        end
        queued += nb;
        note_event(EV_ENQ, e, hi, 1'b0);
        if (serving == SERVE_NONE && send_st == SEND_READY)
            begin_service();
    endfunction

    function automatic void model_complete();
        logic [ENTRY_W-1:0] e;
        logic hi;
        logic ecn;
        int unsigned sz;
        if (serving == SERVE_NONE)
            return;
        hi = (serving == SERVE_HIGH);
        if ((hi ? hi_cnt : lo_cnt) == 0) begin
            serving = SERVE_NONE;
            return;
        end
        if (hi) begin
            e = hi_ring[hi_head % DEPTH];
            hi_head = (hi_head + 1) % DEPTH;
            hi_cnt--;
        end else begin
            e = lo_ring[lo_head % DEPTH];
            lo_head = (lo_head + 1) % DEPTH;
            lo_cnt--;
        end
        if (send_st == SEND_PAUSE_RECEIVED)
            send_st = SEND_PAUSED;
        ecn = (queued > mark_thr) ? ECN_CE : 1'b0;
        sz = e[ENTRY_W-1:TAG_W];
        queued -= (sz <= queued) ? sz : queued;
        serving = SERVE_NONE;
        note_event(EV_DEPART, e, hi, ecn);
        if (send_st == SEND_READY)
            begin_service();
    endfunction

    // Predict all results of one accepted item and flag the final one
    function automatic void predict_item(input logic [1:0] op, input logic [15:0] tag,
                                         input logic [13:0] nb, input logic hi,
                                         input logic pz);
        int before_n;
        before_n = pending_events.size();
        if (op == OP_ARRIVAL) begin
            model_arrival(tag, nb, hi);
        end else if (op == OP_PAUSE) begin
            if (pz) begin
                send_st = (serving != SERVE_NONE) ? SEND_PAUSE_RECEIVED : SEND_PAUSED;
            end else begin
                send_st = SEND_READY;
                if (serving == SERVE_NONE)
                    begin_service();
            end
        end else if (op == OP_COMPLETE) begin
            model_complete();
        end
        if (pending_events.size() > before_n)
            pending_events[pending_events.size()-1].last = 1'b1;
    endfunction

    // Check each strobed result against the oldest prediction
    always @(posedge clk) begin
        res_t want;
        if (rst_n && strobe) begin
            if (pending_events.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result kind=%0d tag=%h", event_kind, out_tag);
            end else begin
                want = pending_events[0];
                pending_events.delete(0);
                if (event_kind !== want.kind || out_tag !== want.tag ||
                    out_bytes !== want.bytes || from_high !== want.from_high ||
                    ecn_marked !== want.ecn || occupancy !== want.occ ||
                    last !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch exp k=%0d t=%h b=%0d h=%b e=%b o=%0d l=%b got k=%0d t=%h b=%0d h=%b e=%b o=%0d l=%b",
                                 want.kind, want.tag, want.bytes, want.from_high, want.ecn,
                                 want.occ, want.last, event_kind, out_tag, out_bytes,
                                 from_high, ecn_marked, occupancy, last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Send one item; hold start until it is taken
    task automatic send_item(input logic [1:0] op, input logic [15:0] tag,
                             input logic [13:0] nb, input logic hi, input logic pz);
        opcode       <= op;
        packet_tag   <= tag;
        packet_bytes <= nb;
        is_high      <= hi;
        pause_on     <= pz;
        start        <= 1'b1;
        do @(posedge clk); while (busy);
        predict_item(op, tag, nb, hi, pz);
        if (!no_idle && $urandom_range(99) < 26) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    // Drain every expected result, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int unsigned val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[23:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MAX_BYTES)
            cap_bytes = val & 24'hFFFFFF;
        else
            mark_thr = val & 24'hFFFFFF;
        @(posedge clk);
    endtask

    task automatic test_service_order();
        send_item(OP_ARRIVAL, 16'h0000, 14'd16383, 1'b0, 1'b0);
        send_item(OP_ARRIVAL, 16'hFFFF, 14'd1, 1'b1, 1'b1);
        send_item(OP_ARRIVAL, 16'h1234, 14'd0, 1'b1, 1'b0);
        send_item(OP_COMPLETE, 16'hFFFF, 14'h3FFF, 1'b1, 1'b1);
        send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
    endtask

    task automatic test_pause_resume();
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b1);
        send_item(OP_ARRIVAL, 16'h00A1, 14'd100, 1'b0, 1'b0);
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_ARRIVAL, 16'h00A2, 14'd200, 1'b1, 1'b0);
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b1);
        send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
        send_item(2'd3, 16'hBEEF, 14'd55, 1'b1, 1'b1);
    endtask

    task automatic test_full_store();
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b1);
        for (int i = 0; i <= DEPTH; i++)
            send_item(OP_ARRIVAL, 16'(i), 14'd10, 1'b1, 1'b0);
        send_item(OP_PAUSE, 16'h0, 14'd0, 1'b0, 1'b0);
        for (int i = 0; i < DEPTH; i++)
            send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
    endtask

    task automatic test_pushout();
        write_reg(CFG_MAX_BYTES, 1000);
        write_reg(CFG_ECN_THRESHOLD, 0);
        for (int i = 0; i < 4; i++)
            send_item(OP_ARRIVAL, 16'(16'h0200 + i), 14'd240, 1'b0, 1'b0);
        send_item(OP_ARRIVAL, 16'h0300, 14'd700, 1'b1, 1'b0);
        send_item(OP_ARRIVAL, 16'h0301, 14'd900, 1'b1, 1'b0);
        send_item(OP_ARRIVAL, 16'h0302, 14'd50, 1'b0, 1'b0);
        for (int i = 0; i < 4; i++)
            send_item(OP_COMPLETE, 16'h0, 14'd0, 1'b0, 1'b0);
    endtask

    // Random traffic, mostly arrivals and completions
    task automatic test_random(input int n_items, input int unsigned max_sz);
        int unsigned pick;
        logic [13:0] nb;
        for (int i = 0; i < n_items; i++) begin
            no_idle = (i >= n_items / 3 && i < n_items / 3 + 30);
            pick = $urandom_range(99);
            case ($urandom_range(19))
                0:       nb = 14'($urandom_range(16383));
                1:       nb = 14'd0;
                default: nb = 14'($urandom_range(max_sz, 1));
            endcase
            if (pick < 55)
                send_item(OP_ARRIVAL, 16'($urandom), nb, 1'($urandom), 1'($urandom));
            else if (pick < 87)
                send_item(OP_COMPLETE, 16'($urandom), 14'($urandom), 1'($urandom),
                          1'($urandom));
            else if (pick < 96)
                send_item(OP_PAUSE, 16'($urandom), 14'($urandom), 1'($urandom),
                          1'($urandom_range(99) < 40));
            else
                send_item(2'd3, 16'($urandom), 14'($urandom), 1'($urandom), 1'($urandom));
        end
        no_idle = 1'b0;
    endtask

    initial begin
        start = 1'b0; opcode = OP_ARRIVAL; packet_tag = '0; packet_bytes = '0;
        is_high = 1'b0; pause_on = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        hi_head = 0; hi_cnt = 0; lo_head = 0; lo_cnt = 0; queued = 0;
        cap_bytes = MAX_BYTES_RESET; mark_thr = ECN_THR_RESET;
        send_st = SEND_READY; serving = SERVE_NONE;
        fail_cnt = 0; cycle_cnt = 0; no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);

        test_service_order();
        test_pause_resume();
        test_full_store();
        test_pushout();

        write_reg(CFG_MAX_BYTES, 65536);
        write_reg(CFG_ECN_THRESHOLD, 32768);
        test_random(60, 6000);
        write_reg(CFG_MAX_BYTES, 24'hFFFFFF);
        write_reg(CFG_ECN_THRESHOLD, 0);
        test_random(40, 16383);
        write_reg(CFG_MAX_BYTES, 3000);
        write_reg(CFG_ECN_THRESHOLD, 800);
        test_random(70, 700);
        write_reg(CFG_MAX_BYTES, 0);
        write_reg(CFG_ECN_THRESHOLD, 24'hFFFFFF);
        test_random(20, 50);
        write_reg(CFG_MAX_BYTES, 8000);
        write_reg(CFG_ECN_THRESHOLD, 4000);
        test_random(25, 2000);

        drain();
        if (fail_cnt == 0 && pending_events.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
